>>> sv/grid_triplet_hinge_loss_defines.svh
// assertion macros shared by the grid triplet hinge loss rtl
// no dependencies; files that check their own logic include this header
`ifndef GRID_TRIPLET_HINGE_LOSS_DEFINES_SVH
`define GRID_TRIPLET_HINGE_LOSS_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GTHL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gthl assertion failed");

// antecedent implies consequent in the next cycle
`define GTHL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gthl assertion failed");

`endif

>>> sv/gthl_pkg.sv
// shared widths, constants and interface structs of the grid triplet hinge loss
// no dependencies; used by all rtl modules through scoped names
package gthl_pkg;

	localparam int FEAT_W   = 16;
	localparam int MAG_W    = 16;
	localparam int SQ_W     = 32;
	localparam int DIST_W   = 43;
	localparam int HINGE_W  = 44;
	localparam int HSUM_W   = 45;
	localparam int LOSS_W   = 64;
	localparam int OUT_W    = 63;
	localparam int COUNT_W  = 21;
	localparam int DIVSR_W  = 22;
	localparam int MARGIN_W = 32;
	localparam int DIV_STEPS = 64;
	localparam int STEP_W   = 6;

	localparam logic [MARGIN_W-1:0] MARGIN_RESET = 32'd65536;
	localparam logic [DIST_W-1:0]   DIST_MAX     = {DIST_W{1'b1}};

	// one classified request waiting between front and back
	typedef struct packed {
		logic [MAG_W-1:0] mag_pos;   // |second - first|
		logic [MAG_W-1:0] mag_neg1;  // |negative - first|
		logic [MAG_W-1:0] mag_neg2;  // |negative - second|
		logic             close;     // ends a position
		logic             batch_end; // ends the batch
	} queue_entry_t;

	// batch totals handed to the divider
	typedef struct packed {
		logic [LOSS_W-1:0]  dividend;
		logic [DIVSR_W-1:0] divisor;
		logic               sat;
	} div_req_t;

endpackage

>>> sv/gthl_front.sv
// front end: accepts requests, forms absolute feature differences, queues them
// depends on gthl_pkg and grid_triplet_hinge_loss_defines.svh
`include "grid_triplet_hinge_loss_defines.svh"

module gthl_front #(
	parameter int DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [gthl_pkg::FEAT_W-1:0] feat_first,
	input  logic signed [gthl_pkg::FEAT_W-1:0] feat_second,
	input  logic signed [gthl_pkg::FEAT_W-1:0] feat_negative,
	input  logic                                last_channel,
	input  logic                                last_position,
	input  logic                                pop,
	output logic                                q_valid,
	output gthl_pkg::queue_entry_t              q_entry
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	gthl_pkg::queue_entry_t mem_q [DEPTH];
	gthl_pkg::queue_entry_t wr_entry;
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic push;

	function automatic logic [gthl_pkg::MAG_W-1:0] abs_diff(
		input logic signed [gthl_pkg::FEAT_W-1:0] a,
		input logic signed [gthl_pkg::FEAT_W-1:0] b
	);
		logic signed [gthl_pkg::FEAT_W:0] d;
		logic [gthl_pkg::FEAT_W:0] m;
		d = {a[gthl_pkg::FEAT_W-1], a} - {b[gthl_pkg::FEAT_W-1], b};
		m = d[gthl_pkg::FEAT_W] ? (~d + 1'b1) : d;
		return m[gthl_pkg::MAG_W-1:0];
	endfunction

	assign in_ready = (count_q != CNT_W'(DEPTH));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign q_entry  = mem_q[rptr_q];

	always_comb begin
		wr_entry.mag_pos   = abs_diff(feat_second, feat_first);
		wr_entry.mag_neg1  = abs_diff(feat_negative, feat_first);
		wr_entry.mag_neg2  = abs_diff(feat_negative, feat_second);
		wr_entry.close     = last_channel || last_position;
		wr_entry.batch_end = last_position;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`GTHL_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, count_q != '0)
	`GTHL_ASSERT_NEXT(a_push_grows, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)
	`GTHL_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))

endmodule

>>> sv/gthl_back.sv
// back end: squares, distance sums, hinges and the saturating loss sum
// depends on gthl_pkg; hands batch totals to gthl_div
module gthl_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [gthl_pkg::MARGIN_W-1:0]  cfg_data,
	input  logic                           q_valid,
	input  gthl_pkg::queue_entry_t         q_entry,
	output logic                           pop,
	input  logic                           div_busy,
	output logic                           req_valid,
	output gthl_pkg::div_req_t             req
);

	logic [gthl_pkg::MARGIN_W-1:0] margin_q;

	// stage 1: squares
	logic                        v_s1, close_s1, end_s1;
	logic [gthl_pkg::SQ_W-1:0]   sq_pos_s1, sq_neg1_s1, sq_neg2_s1;

	// stage 2: running distance sums, closed sums out
	logic [gthl_pkg::DIST_W-1:0] acc_pos_q, acc_neg1_q, acc_neg2_q;
	logic                        pos_sat_q;
	logic                        v_s2, end_s2, sat_s2;
	logic [gthl_pkg::DIST_W-1:0] dpos_s2, dneg1_s2, dneg2_s2;

	// stage 3: hinges
	logic                         v_s3, end_s3, sat_s3;
	logic [gthl_pkg::HINGE_W-1:0] h1_s3, h2_s3;

	// stage 4: hinge pair sum
	logic                        v_s4, end_s4, sat_s4;
	logic [gthl_pkg::HSUM_W-1:0] hsum_s4;

	// batch state
	logic [gthl_pkg::LOSS_W-1:0]  loss_sum_q;
	logic [gthl_pkg::COUNT_W-1:0] count_q;
	logic                         batch_sat_q;

	logic go;
	logic [gthl_pkg::DIST_W:0]   sum_pos, sum_neg1, sum_neg2;
	logic [gthl_pkg::DIST_W-1:0] new_pos, new_neg1, new_neg2;
	logic                        dsat;
	logic [gthl_pkg::HINGE_W-1:0] h1, h2;
	logic [gthl_pkg::LOSS_W:0]    loss_total;
	logic [gthl_pkg::LOSS_W-1:0]  new_loss;
	logic [gthl_pkg::COUNT_W-1:0] new_count;
	logic                         new_sat;

	function automatic logic [gthl_pkg::HINGE_W-1:0] hinge(
		input logic [gthl_pkg::DIST_W-1:0]   dpos,
		input logic [gthl_pkg::DIST_W-1:0]   dneg,
		input logic [gthl_pkg::MARGIN_W-1:0] m
	);
		logic [gthl_pkg::HINGE_W-1:0] a;
		logic [gthl_pkg::HINGE_W-1:0] d;
		a = {1'b0, dpos} + {{(gthl_pkg::HINGE_W - gthl_pkg::MARGIN_W){1'b0}}, m};
		d = a - {1'b0, dneg};
		return (a > {1'b0, dneg}) ? d : '0;
	endfunction

	// only a batch end at the loss stage waits for the divider
	assign go  = !(div_busy && v_s4 && end_s4);
	assign pop = go && q_valid;

	always_comb begin
		sum_pos  = {1'b0, acc_pos_q}  + {{(gthl_pkg::DIST_W + 1 - gthl_pkg::SQ_W){1'b0}}, sq_pos_s1};
		sum_neg1 = {1'b0, acc_neg1_q} + {{(gthl_pkg::DIST_W + 1 - gthl_pkg::SQ_W){1'b0}}, sq_neg1_s1};
		sum_neg2 = {1'b0, acc_neg2_q} + {{(gthl_pkg::DIST_W + 1 - gthl_pkg::SQ_W){1'b0}}, sq_neg2_s1};
		new_pos  = sum_pos[gthl_pkg::DIST_W]  ? gthl_pkg::DIST_MAX : sum_pos[gthl_pkg::DIST_W-1:0];
		new_neg1 = sum_neg1[gthl_pkg::DIST_W] ? gthl_pkg::DIST_MAX : sum_neg1[gthl_pkg::DIST_W-1:0];
		new_neg2 = sum_neg2[gthl_pkg::DIST_W] ? gthl_pkg::DIST_MAX : sum_neg2[gthl_pkg::DIST_W-1:0];
		dsat     = sum_pos[gthl_pkg::DIST_W] || sum_neg1[gthl_pkg::DIST_W]
			|| sum_neg2[gthl_pkg::DIST_W];

		h1 = hinge(dpos_s2, dneg1_s2, margin_q);
		h2 = hinge(dpos_s2, dneg2_s2, margin_q);

		// one saturating add of both hinges matches two in a row
		loss_total = {1'b0, loss_sum_q}
			+ {{(gthl_pkg::LOSS_W + 1 - gthl_pkg::HSUM_W){1'b0}}, hsum_s4};
		new_loss   = loss_total[gthl_pkg::LOSS_W] ? {gthl_pkg::LOSS_W{1'b1}}
			: loss_total[gthl_pkg::LOSS_W-1:0];
		new_count  = (count_q == {gthl_pkg::COUNT_W{1'b1}}) ? count_q : count_q + 1'b1;
		new_sat    = batch_sat_q || sat_s4 || loss_total[gthl_pkg::LOSS_W];

		req_valid    = go && v_s4 && end_s4;
		req.dividend = new_loss;
		req.divisor  = {new_count, 1'b0};
		req.sat      = new_sat;
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (go) begin
			sq_pos_s1  <= q_entry.mag_pos  * q_entry.mag_pos;
			sq_neg1_s1 <= q_entry.mag_neg1 * q_entry.mag_neg1;
			sq_neg2_s1 <= q_entry.mag_neg2 * q_entry.mag_neg2;
			close_s1   <= q_entry.close;
			end_s1     <= q_entry.batch_end;
			dpos_s2    <= new_pos;
			dneg1_s2   <= new_neg1;
			dneg2_s2   <= new_neg2;
			end_s2     <= end_s1;
			sat_s2     <= pos_sat_q || dsat;
			h1_s3      <= h1;
			h2_s3      <= h2;
			end_s3     <= end_s2;
			sat_s3     <= sat_s2;
			hsum_s4    <= {1'b0, h1_s3} + {1'b0, h2_s3};
			end_s4     <= end_s3;
			sat_s4     <= sat_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q    <= gthl_pkg::MARGIN_RESET;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			acc_pos_q   <= '0;
			acc_neg1_q  <= '0;
			acc_neg2_q  <= '0;
			pos_sat_q   <= 1'b0;
			loss_sum_q  <= '0;
			count_q     <= '0;
			batch_sat_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				margin_q <= cfg_data;
			end
			if (go) begin
				v_s1 <= q_valid;
				v_s2 <= v_s1 && close_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				if (v_s1) begin
					if (close_s1) begin
						acc_pos_q  <= '0;
						acc_neg1_q <= '0;
						acc_neg2_q <= '0;
						pos_sat_q  <= 1'b0;
					end else begin
						acc_pos_q  <= new_pos;
						acc_neg1_q <= new_neg1;
						acc_neg2_q <= new_neg2;
						pos_sat_q  <= pos_sat_q || dsat;
					end
				end
				if (v_s4) begin
					if (end_s4) begin
						loss_sum_q  <= '0;
						count_q     <= '0;
						batch_sat_q <= 1'b0;
					end else begin
						loss_sum_q  <= new_loss;
						count_q     <= new_count;
						batch_sat_q <= new_sat;
					end
				end
			end
		end
	end

endmodule

>>> sv/gthl_div.sv
// batch end divider: restoring division one bit a cycle, plus the output register
// depends on gthl_pkg and grid_triplet_hinge_loss_defines.svh
`include "grid_triplet_hinge_loss_defines.svh"

module gthl_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  gthl_pkg::div_req_t            req,
	output logic                          busy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gthl_pkg::OUT_W-1:0]    loss,
	output logic                          overflowed
);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		DONE
	} state_t;

	state_t                        state_q;
	logic [gthl_pkg::LOSS_W-1:0]   num_q;
	logic [gthl_pkg::DIVSR_W-1:0]  den_q;
	logic [gthl_pkg::DIVSR_W-1:0]  rem_q;
	logic [gthl_pkg::STEP_W-1:0]   step_q;
	logic                          den_zero_q;
	logic                          sat_q;
	logic                          out_valid_q;
	logic [gthl_pkg::OUT_W-1:0]    loss_q;
	logic                          overflowed_q;

	logic [gthl_pkg::DIVSR_W:0]    trial;
	logic [gthl_pkg::DIVSR_W:0]    trial_diff;
	logic                          qbit;
	logic                          out_free;

	assign busy       = (state_q != IDLE);
	assign out_valid  = out_valid_q;
	assign loss       = loss_q;
	assign overflowed = overflowed_q;
	assign out_free   = !out_valid_q || out_ready;

	always_comb begin
		trial      = {rem_q, num_q[gthl_pkg::LOSS_W-1]};
		trial_diff = trial - {1'b0, den_q};
		qbit       = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			num_q        <= '0;
			den_q        <= '0;
			rem_q        <= '0;
			step_q       <= '0;
			den_zero_q   <= 1'b0;
			sat_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			loss_q       <= '0;
			overflowed_q <= 1'b0;
		end else begin
			// new result loads, or the held one stays until taken
			out_valid_q <= (state_q == DONE && out_free) || (out_valid_q && !out_ready);
			unique case (state_q)
				IDLE: begin
					if (req_valid) begin
						num_q      <= req.dividend;
						den_q      <= req.divisor;
						rem_q      <= '0;
						step_q     <= gthl_pkg::STEP_W'(gthl_pkg::DIV_STEPS - 1);
						den_zero_q <= (req.divisor == '0);
						sat_q      <= req.sat;
						state_q    <= RUN;
					end
				end
				RUN: begin
					rem_q <= qbit ? trial_diff[gthl_pkg::DIVSR_W-1:0]
						: trial[gthl_pkg::DIVSR_W-1:0];
					num_q <= {num_q[gthl_pkg::LOSS_W-2:0], qbit};
					if (step_q == '0) begin
						state_q <= DONE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				DONE: begin
					if (out_free) begin
						loss_q       <= den_zero_q ? '0 : num_q[gthl_pkg::OUT_W-1:0];
						overflowed_q <= sat_q;
						state_q      <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`GTHL_ASSERT_IMPL(a_req_when_idle, clk, arst_n, req_valid, state_q == IDLE)
	`GTHL_ASSERT_NEXT(a_run_ends, clk, arst_n, state_q == RUN && step_q == '0, state_q == DONE)
	`GTHL_ASSERT_NEXT(a_done_shows, clk, arst_n, state_q == DONE && out_free, out_valid_q && state_q == IDLE)

endmodule

>>> sv/grid_triplet_hinge_loss.sv
// top level of the grid triplet hinge loss block
// depends on gthl_pkg, gthl_front, gthl_back and gthl_div
//
// Squared-euclidean triplet margin loss over a feature grid. Each request
// carries one channel of a first positive, a second positive and a negative
// Q8.8 feature at one grid position; last_channel closes the position and
// last_position closes both the position and the batch. The block takes one
// request per cycle unless its queue is full: the front forms the three
// absolute differences and queues them, the back squares them, keeps the
// three distance sums, forms both hinges when a position closes and adds them
// to a saturating 64-bit loss sum. A batch end hands sum and doubled position
// count to a restoring divider that resolves one quotient bit a cycle over 64
// divide steps. A closing request passes the queue, the square, distance sum,
// hinge and hinge sum registers to the loss stage, loads the divider, runs the
// divide steps and then loads the output register. While that divide runs,
// channels of the next batch keep flowing; only a second batch end reaching
// the loss stage waits for the divider, which stays busy while a result
// waits for out_ready. The margin register is written through the cfg
// channel, which is always ready, and must be written only while idle.
module grid_triplet_hinge_loss #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gthl_pkg::MARGIN_W-1:0]       cfg_data,
	// input request channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [gthl_pkg::FEAT_W-1:0] feat_first,
	input  logic signed [gthl_pkg::FEAT_W-1:0] feat_second,
	input  logic signed [gthl_pkg::FEAT_W-1:0] feat_negative,
	input  logic                                last_channel,
	input  logic                                last_position,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [gthl_pkg::OUT_W-1:0]          loss,
	output logic                                overflowed
);

	// queue between front and back
	logic                   q_valid;
	logic                   pop;
	gthl_pkg::queue_entry_t q_entry;

	// batch totals to the divider
	logic                   req_valid;
	gthl_pkg::div_req_t     req;
	logic                   div_busy;

	// margin register sits in the back and takes every write
	assign cfg_ready = 1'b1;

	// accept and classify, difference magnitudes, short queue
	gthl_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.feat_first   (feat_first),
		.feat_second  (feat_second),
		.feat_negative(feat_negative),
		.last_channel (last_channel),
		.last_position(last_position),
		.pop          (pop),
		.q_valid      (q_valid),
		.q_entry      (q_entry)
	);

	// squares, distance sums, hinges, loss sum and position count
	gthl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.pop      (pop),
		.div_busy (div_busy),
		.req_valid(req_valid),
		.req      (req)
	);

	// mean over doubled position count, then the output register
	gthl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.busy      (div_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.loss      (loss),
		.overflowed(overflowed)
	);

endmodule

>>> bench/tb_grid_triplet_hinge_loss.sv
// self-checking testbench of the grid triplet hinge loss block
// depends on gthl_pkg and grid_triplet_hinge_loss; a scoreboard class
// predicts every batch loss and plain tasks drive the request channels
module tb_grid_triplet_hinge_loss;

	// quiet cycles allowed with no handshake on any channel
	localparam int STALL_LIMIT     = 4000;
	// one long receiver hold-off so the block backs up into its input
	localparam int PRESSURE_CYCLES = 400;
	// settle time after the last result; covers the divide and back stages
	localparam int DRAIN_CYCLES    = 100;
	localparam int MAX_REPORTS     = 10;

	localparam int FW = gthl_pkg::FEAT_W;

	typedef struct {
		logic signed [FW-1:0] first;
		logic signed [FW-1:0] second;
		logic signed [FW-1:0] negative;
		logic                 end_chan;
		logic                 end_batch;
	} triplet_req_t;

	typedef struct {
		logic [gthl_pkg::OUT_W-1:0] loss;
		logic                       ovf;
	} loss_result_t;

	// predicts the loss of each batch and holds the losses still to come
	class loss_scoreboard;
		logic [gthl_pkg::MARGIN_W-1:0] margin;
		logic [63:0]                   pos_acc;
		logic [63:0]                   neg1_acc;
		logic [63:0]                   neg2_acc;
		logic [gthl_pkg::LOSS_W-1:0]   loss_acc;
		logic [gthl_pkg::COUNT_W-1:0]  positions;
		bit                            sat;
		loss_result_t                  expected_losses[$];
		int                            errors;

		function new();
			margin = gthl_pkg::MARGIN_RESET;
			errors = 0;
			clear_batch();
		endfunction

		function void clear_batch();
			pos_acc   = '0;
			neg1_acc  = '0;
			neg2_acc  = '0;
			loss_acc  = '0;
			positions = '0;
			sat       = 1'b0;
		endfunction

		function void set_margin(logic [gthl_pkg::MARGIN_W-1:0] value);
			margin = value;
		endfunction

		// exact square of a 17-bit difference, Q.16
		function logic [63:0] sq_dist(logic signed [FW-1:0] a, logic signed [FW-1:0] b);
			logic signed [FW:0] d;
			logic [FW:0]        m;
			d = a - b;
			m = d[FW] ? -d : d;
			return 64'(m) * 64'(m);
		endfunction

		// distance sums clip at the 43-bit maximum
		function logic [63:0] dist_add(logic [63:0] acc, logic [63:0] add);
			logic [63:0] s;
			s = acc + add;
			if (s > 64'(gthl_pkg::DIST_MAX)) begin
				sat = 1'b1;
				return 64'(gthl_pkg::DIST_MAX);
			end
			return s;
		endfunction

		function logic [63:0] hinge(logic [63:0] dpos, logic [63:0] dneg);
			logic [63:0] a;
			a = dpos + 64'(margin);
			return (a > dneg) ? a - dneg : 64'd0;
		endfunction

		function void add_hinge(logic [63:0] h);
			logic [64:0] s;
			s = {1'b0, loss_acc} + {1'b0, h};
			if (s[64]) begin
				loss_acc = '1;
				sat = 1'b1;
			end else begin
				loss_acc = s[63:0];
			end
		endfunction

		function void note_request(triplet_req_t r);
			logic [63:0]  divisor;
			logic [63:0]  quot;
			loss_result_t res;
			pos_acc  = dist_add(pos_acc, sq_dist(r.second, r.first));
			neg1_acc = dist_add(neg1_acc, sq_dist(r.negative, r.first));
			neg2_acc = dist_add(neg2_acc, sq_dist(r.negative, r.second));
			// a batch end closes its position even without last_channel
			if (r.end_chan || r.end_batch) begin
				add_hinge(hinge(pos_acc, neg1_acc));
				add_hinge(hinge(pos_acc, neg2_acc));
				if (positions != '1)
					positions++;
				pos_acc  = '0;
				neg1_acc = '0;
				neg2_acc = '0;
			end
			if (r.end_batch) begin
				divisor = 64'(positions) << 1;
				quot = (divisor != 0) ? loss_acc / divisor : 64'd0;
				res.loss = quot[gthl_pkg::OUT_W-1:0];
				res.ovf  = sat;
				expected_losses.push_back(res);
				clear_batch();
			end
		endfunction

		function void check_loss(logic [gthl_pkg::OUT_W-1:0] got_loss, logic got_ovf);
			loss_result_t want;
			if (expected_losses.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected result: loss %0d overflowed %0b", got_loss, got_ovf);
				return;
			end
			want = expected_losses.pop_front();
			if (got_loss !== want.loss || got_ovf !== want.ovf) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("loss mismatch: expected %0d/%0b, actual %0d/%0b",
						want.loss, want.ovf, got_loss, got_ovf);
			end
		endfunction

		function int outstanding();
			return expected_losses.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [gthl_pkg::MARGIN_W-1:0] cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic signed [FW-1:0]          feat_first;
	logic signed [FW-1:0]          feat_second;
	logic signed [FW-1:0]          feat_negative;
	logic                          last_channel;
	logic                          last_position;
	logic                          out_valid;
	logic                          out_ready;
	logic [gthl_pkg::OUT_W-1:0]    loss;
	logic                          overflowed;

	loss_scoreboard board;
	int             req_count = 0;
	// no sender gaps while set
	bit             eager_in = 1'b0;
	bit             pressure_done = 1'b0;

	grid_triplet_hinge_loss dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.feat_first   (feat_first),
		.feat_second  (feat_second),
		.feat_negative(feat_negative),
		.last_channel (last_channel),
		.last_position(last_position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.loss         (loss),
		.overflowed   (overflowed)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// full-range feature with extra weight on the extremes and zero
	function automatic logic signed [FW-1:0] rand_feat();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			default: return FW'($urandom);
		endcase
	endfunction

	// value a small step away, wrapping at the field edges
	function automatic logic signed [FW-1:0] near(logic signed [FW-1:0] v);
		return v + $signed(FW'($urandom_range(0, 64))) - 16'sd32;
	endfunction

	function automatic triplet_req_t mk_req(logic signed [FW-1:0] f1, logic signed [FW-1:0] f2,
			logic signed [FW-1:0] fn, logic lc, logic lp);
		triplet_req_t r;
		r.first     = f1;
		r.second    = f2;
		r.negative  = fn;
		r.end_chan  = lc;
		r.end_batch = lp;
		return r;
	endfunction

	// offer one request at the falling edge and hold it until accepted
	task automatic send_req(input triplet_req_t r);
		int gap;
		gap = eager_in ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		feat_first    = r.first;
		feat_second   = r.second;
		feat_negative = r.negative;
		last_channel  = r.end_chan;
		last_position = r.end_batch;
		in_valid      = 1'b1;
		do @(posedge clk); while (!in_ready);
		board.note_request(r);
		req_count++;
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// every expected loss in, then let the pipeline settle
	task automatic wait_idle();
		while (board.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_margin(input logic [gthl_pkg::MARGIN_W-1:0] value);
		@(negedge clk);
		cfg_data  = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.set_margin(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one well-formed batch; broken drops last_channel on the closing request
	task automatic send_batch(input int npos, input int max_ch, input bit broken);
		int                   nch;
		int                   mode;
		logic signed [FW-1:0] base;
		triplet_req_t         r;
		for (int p = 0; p < npos; p++) begin
			nch  = $urandom_range(1, max_ch);
			mode = $urandom_range(0, 4);
			base = rand_feat();
			for (int c = 0; c < nch; c++) begin
				r.first    = rand_feat();
				r.second   = rand_feat();
				r.negative = rand_feat();
				case (mode)
					// close positives, hinge mostly zero
					1: r.second = near(r.first);
					// negative close to the anchor, hinge mostly positive
					2: r.negative = near(r.first);
					// all three close, margin dominates
					3: begin
						r.first    = near(base);
						r.second   = near(base);
						r.negative = near(base);
					end
					// negative equals second positive, ties at zero margin
					4: r.negative = r.second;
					default: ;
				endcase
				r.end_chan  = (c == nch - 1);
				r.end_batch = (p == npos - 1) && (c == nch - 1);
				if (broken && r.end_batch)
					r.end_chan = 1'b0;
				send_req(r);
			end
		end
	endtask

	// result side: every accepted result goes straight to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_loss(loss, overflowed);
	end

	// receiver: runs of ready broken by gaps, plus one long hold-off
	initial begin : receiver
		int hold;
		int run;
		hold = 0;
		run = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!pressure_done && req_count >= 120) begin
				hold = PRESSURE_CYCLES;
				pressure_done = 1'b1;
			end else if (hold == 0 && run == 0) begin
				run  = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 200 : 12);
				hold = pick_gap();
			end
			if (hold > 0) begin
				out_ready = 1'b0;
				hold--;
			end else begin
				out_ready = 1'b1;
				run--;
			end
		end
	end

	// watchdog on quiet cycles across all three channels
	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall = 0;
			else
				stall++;
		end
		$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int start;
		board = new();
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		feat_first    = '0;
		feat_second   = '0;
		feat_negative = '0;
		last_channel  = 1'b0;
		last_position = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under the reset margin
		// zero distances, loss equals the margin
		send_req(mk_req(0, 0, 0, 1, 1));
		// widest positive pair with negative on the anchor
		send_req(mk_req(16'sh8000, 16'sh7FFF, 16'sh8000, 1, 1));
		send_req(mk_req(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1, 1));
		// identical positives, negative at the far edge, both hinges zero
		send_req(mk_req(16'sh8000, 16'sh8000, 16'sh7FFF, 1, 1));
		// two positions of three channels
		send_req(mk_req(-1, 1, 0, 0, 0));
		send_req(mk_req(16'sh5555, 16'shAAAA, 16'sh00FF, 0, 0));
		send_req(mk_req(16'shAAAA, 16'sh5555, 16'shFF00, 1, 0));
		send_req(mk_req(-1, -1, -1, 0, 0));
		send_req(mk_req(16'sh0001, 16'sh7FFE, 16'sh8001, 0, 0));
		send_req(mk_req(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1, 1));
		// batch end without channel end
		send_req(mk_req(100, -100, 5, 0, 0));
		send_req(mk_req(-1, 1, 16'sh7FFF, 0, 1));
		// batch end on a fresh position with no channel end
		send_req(mk_req(16'sh1234, 16'shEDCB, 16'sh8000, 1, 0));
		send_req(mk_req(16'sh7FFF, 16'sh8000, 0, 0, 1));
		release_input();
		wait_idle();

		// random batches under several margins, extremes first
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_margin('0);
				1: write_margin('1);
				2: write_margin(gthl_pkg::MARGIN_W'($urandom_range(0, 1 << 20)));
				3: write_margin(gthl_pkg::MARGIN_RESET);
				default: write_margin($urandom);
			endcase
			start = req_count;
			while (req_count - start < 180) begin
				eager_in = ($urandom_range(0, 3) == 0);
				send_batch(($urandom_range(0, 9) == 0) ? $urandom_range(9, 30)
					: $urandom_range(1, 8),
					($urandom_range(0, 9) == 0) ? 32 : 6,
					($urandom_range(0, 9) == 0));
			end
			eager_in = 1'b0;
			release_input();
			wait_idle();
		end

		// noise: flags at random, closed by a batch end
		write_margin(gthl_pkg::MARGIN_W'($urandom_range(0, 1 << 18)));
		start = req_count;
		while (req_count - start < 130)
			send_req(mk_req(rand_feat(), rand_feat(), rand_feat(),
				$urandom_range(0, 2) == 0, $urandom_range(0, 11) == 0));
		send_req(mk_req(rand_feat(), rand_feat(), rand_feat(), 0, 1));
		release_input();
		wait_idle();

		if (board.errors == 0 && board.outstanding() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
